### rtl/tcce_pkg.sv
package tcce_pkg;

  // Field widths fixed by the channel definitions
  localparam int unsigned FuncBits   = 3;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned CellBits   = 8;
  localparam int unsigned GlyphBits  = 7;
  localparam int unsigned CmdBits    = 3;
  localparam int unsigned ColorBits  = 32;
  localparam int unsigned CfgIdxBits = 8;

  // Default width of the internal cursor coordinates
  localparam int unsigned CoordBitsDefault = 8;

  // Plan queue between front and back
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  // Register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] RegColumns   = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegRows      = 8'd1;
  localparam logic [CfgIdxBits-1:0] RegForeColor = 8'd2;
  localparam logic [CfgIdxBits-1:0] RegBackColor = 8'd3;

  // Register values after reset
  localparam logic [CellBits-1:0]  ColumnsReset   = 8'd80;
  localparam logic [CellBits-1:0]  RowsReset      = 8'd25;
  localparam logic [ColorBits-1:0] ForeColorReset = 32'h00FF_FFFF;
  localparam logic [ColorBits-1:0] BackColorReset = 32'h0000_0000;

  // Character codes with special handling
  localparam logic [CharBits-1:0] ChBackspace = 8'd8;
  localparam logic [CharBits-1:0] ChTab       = 8'd9;
  localparam logic [CharBits-1:0] ChNewline   = 8'd10;
  localparam logic [CharBits-1:0] ChReturn    = 8'd13;
  localparam logic [CharBits-1:0] ChSpace     = 8'd32;
  localparam logic [CharBits-1:0] ChDelete    = 8'd127;
  localparam int unsigned         TabStop     = 8;

  // Slots of a plan, emitted from the lowest set slot upwards
  localparam int unsigned PlanSlots   = 4;
  localparam int unsigned SlotEraseCur = 0;
  localparam int unsigned SlotMain     = 1;
  localparam int unsigned SlotScroll   = 2;
  localparam int unsigned SlotDrawCur  = 3;

  typedef enum logic [FuncBits-1:0] {
    FuncPut       = 3'd0,
    FuncSetCursor = 3'd1,
    FuncShowHide  = 3'd2,
    FuncClear     = 3'd3,
    FuncReport    = 3'd4
  } tcce_func_e;

  typedef enum logic [CmdBits-1:0] {
    CmdGlyph     = 3'd0,
    CmdEraseCell = 3'd1,
    CmdDrawCur   = 3'd2,
    CmdEraseCur  = 3'd3,
    CmdScroll    = 3'd4,
    CmdClear     = 3'd5,
    CmdReport    = 3'd6
  } tcce_cmd_e;

  // Everything the back end needs to emit the commands of one operation
  typedef struct packed {
    logic [PlanSlots-1:0] mask;
    tcce_cmd_e            main_cmd;
    logic [CellBits-1:0]  main_col;
    logic [CellBits-1:0]  main_row;
    logic [GlyphBits-1:0] glyph;
    logic [CellBits-1:0]  old_col;
    logic [CellBits-1:0]  old_row;
    logic [CellBits-1:0]  new_col;
    logic [CellBits-1:0]  new_row;
  } tcce_plan_t;

endpackage

### rtl/tcce_if.sv
// Operation channel into the block
interface tcce_item_if;
  import tcce_pkg::*;

  logic                valid;
  logic                ready;
  logic [FuncBits-1:0] func;
  logic [CharBits-1:0] char_code;
  logic [CellBits-1:0] new_col;
  logic [CellBits-1:0] new_row;
  logic                show;

  modport source (output valid, output func, output char_code, output new_col,
                  output new_row, output show, input ready);
  modport sink (input valid, input func, input char_code, input new_col,
                input new_row, input show, output ready);
endinterface

// Drawing command channel out of the block
interface tcce_cmd_if;
  import tcce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CmdBits-1:0]   command;
  logic [CellBits-1:0]  cell_col;
  logic [CellBits-1:0]  cell_row;
  logic [GlyphBits-1:0] glyph_code;
  logic [ColorBits-1:0] paint_color;
  logic [ColorBits-1:0] fill_color;
  logic                 last;

  modport source (output valid, output command, output cell_col, output cell_row,
                  output glyph_code, output paint_color, output fill_color,
                  output last, input ready);
  modport sink (input valid, input command, input cell_col, input cell_row,
                input glyph_code, input paint_color, input fill_color,
                input last, output ready);
endinterface

// Configuration write channel
interface tcce_cfg_if;
  import tcce_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [ColorBits-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/tcce_front.sv
module tcce_front #(
  parameter int unsigned COORD_BITS = tcce_pkg::CoordBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tcce_item_if.sink                     item_i,
  input  logic [tcce_pkg::CellBits-1:0] columns_i,
  input  logic [tcce_pkg::CellBits-1:0] rows_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tcce_pkg::tcce_plan_t          plan_o
);
  import tcce_pkg::*;

  localparam int unsigned SzW = (COORD_BITS > CellBits) ? COORD_BITS : CellBits;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   coord_ext_t;

  localparam coord_t CoordMax = '1;

  coord_t col_q, col_d;
  coord_t row_q, row_d;
  logic   shown_q, shown_d;

  logic [SzW-1:0] max_ext, cols_ext, rows_ext, nc_ext, nr_ext;
  coord_t         cols_eff, rows_eff;
  coord_t         nl_row_inc, nl_row;
  logic           nl_scroll;
  coord_ext_t     tab_pos, col_inc;
  logic           tab_wrap, glyph_wrap, printable;
  logic           accept;
  logic [PlanSlots-1:0] mask;

  // Effective screen size: zero acts as one, capped at the coordinate range
  assign max_ext  = SzW'(CoordMax);
  assign cols_ext = (columns_i == '0) ? SzW'(1) : SzW'(columns_i);
  assign rows_ext = (rows_i == '0) ? SzW'(1) : SzW'(rows_i);
  assign cols_eff = (cols_ext > max_ext) ? CoordMax : COORD_BITS'(cols_ext);
  assign rows_eff = (rows_ext > max_ext) ? CoordMax : COORD_BITS'(rows_ext);

  // Newline from the current row: scroll back when it passes the last row
  assign nl_row_inc = row_q + 1'b1;
  assign nl_scroll  = (nl_row_inc >= rows_eff);
  assign nl_row     = nl_scroll ? (nl_row_inc - 1'b1) : nl_row_inc;

  // Tab stop and glyph advance, one bit wider so that an overflow still compares as a wrap
  assign tab_pos    = ({1'b0, col_q} + (COORD_BITS + 1)'(TabStop))
                      & ~((COORD_BITS + 1)'(TabStop - 1));
  assign tab_wrap   = (tab_pos >= {1'b0, cols_eff});
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign glyph_wrap = (col_inc >= {1'b0, cols_eff});
  assign printable  = (item_i.char_code >= ChSpace) && (item_i.char_code < ChDelete);

  // Requested position, clamped to the screen
  assign nc_ext = SzW'(item_i.new_col);
  assign nr_ext = SzW'(item_i.new_row);

  assign item_i.ready = !q_full_i;
  assign accept       = item_i.valid && item_i.ready;

  // Classify the operation, work out the new cursor and the command plan
  always_comb begin
    col_d           = col_q;
    row_d           = row_q;
    shown_d         = shown_q;
    mask            = '0;
    plan_o.main_cmd = CmdGlyph;
    plan_o.main_col = CellBits'(col_q);
    plan_o.main_row = CellBits'(row_q);
    plan_o.glyph    = '0;
    case (tcce_func_e'(item_i.func))
      FuncPut: begin
        mask[SlotEraseCur] = shown_q;
        case (item_i.char_code)
          ChNewline: begin
            col_d            = '0;
            row_d            = nl_row;
            mask[SlotScroll] = nl_scroll;
          end
          ChReturn: begin
            col_d = '0;
          end
          ChTab: begin
            if (tab_wrap) begin
              col_d            = '0;
              row_d            = nl_row;
              mask[SlotScroll] = nl_scroll;
            end else begin
              col_d = tab_pos[COORD_BITS-1:0];
            end
          end
          ChBackspace: begin
            if (col_q != '0) begin
              col_d           = col_q - 1'b1;
              mask[SlotMain]  = 1'b1;
              plan_o.main_cmd = CmdEraseCell;
              plan_o.main_col = CellBits'(col_q - 1'b1);
            end
          end
          default: begin
            if (printable) begin
              mask[SlotMain]  = 1'b1;
              plan_o.main_cmd = CmdGlyph;
              plan_o.glyph    = item_i.char_code[GlyphBits-1:0];
              if (glyph_wrap) begin
                col_d            = '0;
                row_d            = nl_row;
                mask[SlotScroll] = nl_scroll;
              end else begin
                col_d = col_inc[COORD_BITS-1:0];
              end
            end
          end
        endcase
        mask[SlotDrawCur] = shown_q;
      end
      FuncSetCursor: begin
        mask[SlotEraseCur] = shown_q;
        col_d = (nc_ext < SzW'(cols_eff)) ? COORD_BITS'(nc_ext) : (cols_eff - 1'b1);
        row_d = (nr_ext < SzW'(rows_eff)) ? COORD_BITS'(nr_ext) : (rows_eff - 1'b1);
        mask[SlotDrawCur] = shown_q;
      end
      FuncShowHide: begin
        mask[SlotEraseCur] = shown_q;
        shown_d            = item_i.show;
        mask[SlotDrawCur]  = item_i.show;
      end
      FuncClear: begin
        mask[SlotMain]  = 1'b1;
        plan_o.main_cmd = CmdClear;
        plan_o.main_col = '0;
        plan_o.main_row = '0;
        col_d           = '0;
        row_d           = '0;
      end
      FuncReport: begin
        mask[SlotMain]  = 1'b1;
        plan_o.main_cmd = CmdReport;
      end
      default: begin
        mask = '0;
      end
    endcase
    plan_o.mask    = mask;
    plan_o.old_col = CellBits'(col_q);
    plan_o.old_row = CellBits'(row_q);
    plan_o.new_col = CellBits'(col_d);
    plan_o.new_row = CellBits'(row_d);
  end

  // Operations that draw nothing still update the cursor but queue no plan
  assign push_o = accept && (mask != '0);

  // Cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      shown_q <= 1'b1;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      shown_q <= shown_d;
    end
  end

`ifndef SYNTH
  // Clearing the screen homes the cursor.
  a_clear_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.func == FuncClear) |=> (col_q == '0) && (row_q == '0))
    else $error("cursor not homed after clear");

  // A placed cursor lands on the screen.
  a_set_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.func == FuncSetCursor) |=> (col_q < cols_eff) && (row_q < rows_eff))
    else $error("set cursor left the screen");

  // A tab always leaves the cursor on a tab stop.
  a_tab_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.func == FuncPut) && (item_i.char_code == ChTab)
    |=> (col_q[2:0] == 3'd0))
    else $error("tab left the cursor off a tab stop");
`endif

endmodule

### rtl/tcce_queue.sv
module tcce_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tcce_pkg::tcce_plan_t plan_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output tcce_pkg::tcce_plan_t plan_o
);
  import tcce_pkg::*;

  tcce_plan_t                mem_q [QueueDepth];
  logic [QueuePtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrBits:0]     count_q, count_d;
  logic                      push_do, pop_do;

  assign full_o  = (count_q == (QueuePtrBits + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign plan_o  = mem_q[rd_ptr_q];

  assign push_do = push_i && !full_o;
  assign pop_do  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_do ? (wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_do ? (rd_ptr_q + 1'b1) : rd_ptr_q;
    case ({push_do, pop_do})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Plan storage
  always_ff @(posedge clk_i) begin
    if (push_do) begin
      mem_q[wr_ptr_q] <= plan_i;
    end
  end

`ifndef SYNTH
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueuePtrBits + 1)'(QueueDepth))
    else $error("queue overfilled");

  // The front end never offers a plan to a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("plan offered to a full queue");

  // A lone pop removes exactly one plan.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_do && !push_do |=> count_q == $past(count_q) - 1'b1)
    else $error("fill count wrong after pop");
`endif

endmodule

### rtl/tcce_back.sv
module tcce_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  tcce_pkg::tcce_plan_t           plan_i,
  output logic                           pop_o,
  input  logic [tcce_pkg::ColorBits-1:0] fore_i,
  input  logic [tcce_pkg::ColorBits-1:0] back_i,
  tcce_cmd_if.source                     cmd_o
);
  import tcce_pkg::*;

  tcce_plan_t           cur_q, cur_d;
  logic [PlanSlots-1:0] mask_q, mask_d;
  logic                 out_valid_q, out_valid_d;
  tcce_cmd_e            command_q;
  logic [CellBits-1:0]  cell_col_q, cell_row_q;
  logic [GlyphBits-1:0] glyph_q;
  logic [ColorBits-1:0] paint_q, fill_q;
  logic                 last_q;

  logic                 advance, take, load;
  logic [PlanSlots-1:0] clr, rest, mask_after;
  tcce_cmd_e            e_cmd;
  logic [CellBits-1:0]  e_col, e_row;
  logic [GlyphBits-1:0] e_glyph;

  // Pick the lowest pending slot of the current plan
  always_comb begin
    clr     = '0;
    e_cmd   = CmdEraseCur;
    e_col   = cur_q.old_col;
    e_row   = cur_q.old_row;
    e_glyph = '0;
    if (mask_q[SlotEraseCur]) begin
      clr[SlotEraseCur] = 1'b1;
    end else if (mask_q[SlotMain]) begin
      clr[SlotMain] = 1'b1;
      e_cmd         = cur_q.main_cmd;
      e_col         = cur_q.main_col;
      e_row         = cur_q.main_row;
      e_glyph       = cur_q.glyph;
    end else if (mask_q[SlotScroll]) begin
      clr[SlotScroll] = 1'b1;
      e_cmd           = CmdScroll;
      e_col           = '0;
      e_row           = '0;
    end else begin
      clr[SlotDrawCur] = 1'b1;
      e_cmd            = CmdDrawCur;
      e_col            = cur_q.new_col;
      e_row            = cur_q.new_row;
    end
  end

  // Step through the plan and fetch the next one as the current one ends
  assign advance    = !out_valid_q || cmd_o.ready;
  assign take       = advance && (mask_q != '0);
  assign rest       = mask_q & ~clr;
  assign mask_after = take ? rest : mask_q;
  assign load       = (mask_after == '0) && q_valid_i;
  assign pop_o      = load;
  assign mask_d     = load ? plan_i.mask : mask_after;
  assign cur_d      = load ? plan_i : cur_q;
  assign out_valid_d = advance ? take : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Plan and output payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (take) begin
      command_q  <= e_cmd;
      cell_col_q <= e_col;
      cell_row_q <= e_row;
      glyph_q    <= e_glyph;
      paint_q    <= ((e_cmd == CmdGlyph) || (e_cmd == CmdDrawCur)) ? fore_i : back_i;
      fill_q     <= back_i;
      last_q     <= (rest == '0);
    end
  end

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.command     = command_q;
  assign cmd_o.cell_col    = cell_col_q;
  assign cmd_o.cell_row    = cell_row_q;
  assign cmd_o.glyph_code  = glyph_q;
  assign cmd_o.paint_color = paint_q;
  assign cmd_o.fill_color  = fill_q;
  assign cmd_o.last        = last_q;

`ifndef SYNTH
  // Every plan taken from the queue has at least one command.
  a_plan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (plan_i.mask != '0))
    else $error("empty plan reached the back end");

  // Drawing the cursor always closes a transaction run.
  a_draw_cur_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && (cmd_o.command == CmdDrawCur) |-> cmd_o.last)
    else $error("draw cursor not marked last");

  // A run continues without a gap until its last command.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && cmd_o.ready && !cmd_o.last |=> cmd_o.valid)
    else $error("gap inside a command run");
`endif

endmodule

### rtl/text_console_cursor_engine.sv
// Text console cursor engine.
// item_i takes one console operation per transaction (put character, set
// cursor, show or hide cursor, clear, report). cmd_o gives the cell-level
// drawing commands caused by it, one per transaction, with last set on the
// final command of each run. cfg_i writes the columns, rows, fore_color and
// back_color registers; it is always ready and may be used only while idle.
// An accepted operation reaches cmd_o through the plan queue, the back end's
// plan register and the command output register. The command output register
// issues at most one command per cycle; an operation gives one to four
// commands, four for a glyph that wraps and scrolls with the cursor shown;
// operations that draw nothing give no command.
// The front end updates the cursor and queues the plan of any operation that
// draws in the cycle of acceptance; a four-entry plan queue separates it from
// the output side. When the receiver stalls, the current command is held, the
// plan queue fills and item_i.ready falls once four plans wait.
// Reset puts the cursor at column 0, row 0, shown, and loads the register
// defaults of 80 columns, 25 rows, white foreground and black background.
module text_console_cursor_engine #(
  parameter int unsigned COORD_BITS = tcce_pkg::CoordBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcce_item_if.sink   item_i,
  tcce_cmd_if.source  cmd_o,
  tcce_cfg_if.sink    cfg_i
);
  import tcce_pkg::*;

  logic [CellBits-1:0]  columns_q, rows_q;
  logic [ColorBits-1:0] fore_q, back_q;

  logic       push, pop, q_full, q_valid;
  tcce_plan_t plan_in, plan_out;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= ColumnsReset;
      rows_q    <= RowsReset;
      fore_q    <= ForeColorReset;
      back_q    <= BackColorReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegColumns:   columns_q <= cfg_i.data[CellBits-1:0];
        RegRows:      rows_q    <= cfg_i.data[CellBits-1:0];
        RegForeColor: fore_q    <= cfg_i.data;
        RegBackColor: back_q    <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Front end: accepts operations and plans their commands
  tcce_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .columns_i (columns_q),
    .rows_i    (rows_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .plan_o    (plan_in)
  );

  // Plan queue
  tcce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .plan_i  (plan_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .plan_o  (plan_out)
  );

  // Back end: emits the commands of each plan
  tcce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .plan_i    (plan_out),
    .pop_o     (pop),
    .fore_i    (fore_q),
    .back_i    (back_q),
    .cmd_o     (cmd_o)
  );

endmodule
